// ===== design/lmse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmse_pkg
// Shared types and constants for the link master/slave election block.
// ============================================================================
package lmse_pkg;

    localparam int unsigned CODE_W          = 16;
    localparam int unsigned IN_DATA_W       = 64;
    localparam int unsigned OUT_DATA_W      = 24;
    localparam int unsigned APB_ADDR_W      = 4;
    localparam int unsigned APB_DATA_W      = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Register indexes, one 32-bit word each at byte address 4*index.
    typedef enum logic [1:0] {
        REG_THREE_END   = 2'd0,
        REG_REDUNDANT   = 2'd1,
        REG_SELF_LOOP   = 2'd2,
        REG_LOCAL_RELAY = 2'd3
    } t_reg_idx;

    localparam logic [1:0] LOCAL_RELAY_RST = 2'b11;

    typedef struct packed {
        logic       three_end;
        logic       redundant;
        logic [1:0] self_loop;
        logic [1:0] local_relay;
    } t_cfg;

    // Classified tick as it travels from the front end to the election unit.
    typedef struct packed {
        logic              three_end;
        logic              redundant;
        logic [1:0]        v12;
        logic              v3;
        logic              peer1_master;
        logic [CODE_W-1:0] peer1_code;
        logic              peer2_master;
        logic [CODE_W-1:0] peer2_code;
        logic [CODE_W-1:0] fresh_random;
    } t_item;

    // Queue head as seen by the election unit.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

// ===== design/lmse_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmse_front
// Unpacks a tick and derives channel validity and the third-leg flag.
// ============================================================================
module lmse_front (
    input  lmse_pkg::t_cfg                    i_cfg,
    input  logic [lmse_pkg::IN_DATA_W-1:0]    i_tdata,
    output lmse_pkg::t_item                   o_item
);
    import lmse_pkg::*;

    logic [1:0] w_lrx;
    logic [1:0] w_prx;
    logic [1:0] w_prl;
    logic [1:0] w_tls;
    logic [1:0] w_v12_link;
    logic [1:0] w_v12_relay;

    assign w_lrx = i_tdata[1:0];
    assign w_prx = i_tdata[3:2];
    assign w_prl = i_tdata[5:4];
    assign w_tls = i_tdata[7:6];

    // A channel needs stable receive on both ends and must not be looped back.
    assign w_v12_link  = w_lrx & w_prx & ~i_cfg.self_loop;
    // In three-terminal operation at least one end must also have protection on.
    assign w_v12_relay = w_v12_link & (i_cfg.local_relay | w_prl);

    always_comb begin
        o_item.three_end    = i_cfg.three_end;
        o_item.redundant    = i_cfg.redundant;
        o_item.v12          = i_cfg.three_end ? w_v12_relay : w_v12_link;
        o_item.v3           = (w_v12_relay != 2'b00) && ((w_v12_relay & ~w_tls) == 2'b00);
        o_item.peer1_master = i_tdata[8];
        o_item.peer1_code   = i_tdata[24:9];
        o_item.peer2_master = i_tdata[25];
        o_item.peer2_code   = i_tdata[41:26];
        o_item.fresh_random = i_tdata[57:42];
    end

endmodule

// ===== design/lmse_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmse_fifo
// Short register queue between the front end and the election unit.
// ============================================================================
module lmse_fifo #(
    parameter int unsigned DEPTH = lmse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmse_pkg::t_item i_push_item,
    output logic            o_full,
    input  logic            i_pop,
    output lmse_pkg::t_head o_head
);
    import lmse_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

// ===== design/lmse_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmse_back
// Election unit: applies the master/slave rules and holds the result register.
// ============================================================================
module lmse_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lmse_pkg::t_head                  i_head,
    output logic                             o_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lmse_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import lmse_pkg::*;

    logic              r_master;
    logic [CODE_W-1:0] r_code;
    logic [2:0]        r_vmask;
    logic              r_renew;
    logic              r_out_valid;

    logic              n_master;
    logic [CODE_W-1:0] n_code;
    logic [2:0]        n_vmask;
    logic              n_renew;

    logic              w_gt1, w_eq1, w_lt1;
    logic              w_gt2, w_eq2, w_lt2;
    logic              w_pm;
    logic              w_gt, w_eq, w_lt;
    logic              w_use1;
    logic              w_use2;
    logic [1:0]        w_cnt;
    t_item             w_it;

    assign w_it  = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || m_tready);

    assign w_gt1 = r_code > w_it.peer1_code;
    assign w_eq1 = r_code == w_it.peer1_code;
    assign w_lt1 = !w_gt1 && !w_eq1;
    assign w_gt2 = r_code > w_it.peer2_code;
    assign w_eq2 = r_code == w_it.peer2_code;
    assign w_lt2 = !w_gt2 && !w_eq2;

    // Peer choice for the single-peer rules: channel 1 wins when valid.
    assign w_use1 = w_it.v12[0];
    assign w_use2 = !w_it.v12[0] && w_it.v12[1];
    assign w_pm   = w_use1 ? w_it.peer1_master : w_it.peer2_master;
    assign w_gt   = w_use1 ? w_gt1 : w_gt2;
    assign w_eq   = w_use1 ? w_eq1 : w_eq2;
    assign w_lt   = w_use1 ? w_lt1 : w_lt2;

    assign w_cnt = 2'(r_master) + 2'(w_it.peer1_master) + 2'(w_it.peer2_master);

    always_comb begin
        n_master = r_master;
        n_code   = r_code;
        n_renew  = 1'b0;
        if (!w_it.three_end) begin
            n_vmask = {r_vmask[2], w_it.v12};
            if (w_use1 || (w_it.redundant && w_use2)) begin
                if (r_master && w_pm) begin
                    n_master = 1'b0;
                end else if (!r_master && !w_pm) begin
                    if (w_gt) begin
                        n_master = 1'b1;
                    end else if (w_eq) begin
                        n_code  = w_it.fresh_random;
                        n_renew = 1'b1;
                    end
                end
            end else begin
                n_master = 1'b0;
            end
        end else begin
            n_vmask = {w_it.v3, w_it.v12};
            unique case (n_vmask)
                3'b111: begin
                    if (w_cnt == 2'd0) begin
                        if (w_gt1 && w_gt2) begin
                            n_master = 1'b1;
                        end else if (w_eq1 || w_eq2) begin
                            n_code  = w_it.fresh_random;
                            n_renew = 1'b1;
                        end
                    end else if (w_cnt != 2'd1 && r_master && !(w_gt1 && w_gt2)) begin
                        n_master = 1'b0;
                        if (w_eq1 || w_eq2) begin
                            n_code  = w_it.fresh_random;
                            n_renew = 1'b1;
                        end
                    end
                end
                3'b011: begin
                    n_master = 1'b1;
                end
                3'b001, 3'b010: begin
                    if (!r_master && !w_pm) begin
                        if (w_gt) begin
                            n_master = 1'b1;
                        end else if (w_eq) begin
                            n_code  = w_it.fresh_random;
                            n_renew = 1'b1;
                        end
                    end else if (r_master && w_pm) begin
                        if (w_lt) begin
                            n_master = 1'b0;
                        end else if (w_eq) begin
                            n_code  = w_it.fresh_random;
                            n_renew = 1'b1;
                        end
                    end
                end
                default: begin
                    n_master = 1'b0;
                end
            endcase
        end
    end

    // The election state doubles as the result register: it only changes when
    // a tick is popped, which is also when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= 1'b0;
            r_code      <= '0;
            r_vmask     <= '0;
            r_renew     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_master    <= n_master;
                r_code      <= n_code;
                r_vmask     <= n_vmask;
                r_renew     <= n_renew;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_renew, r_vmask, r_code, r_master};

`ifndef ASSERT_OFF
    a_code_only_on_renew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_code)) |-> r_renew)
        else $error("local code changed without a renewal");

    a_two_end_keeps_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !w_it.three_end) |=> (r_vmask[2] == $past(r_vmask[2])))
        else $error("third-leg bit changed in two-terminal mode");

    a_two_valid_is_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_it.three_end && w_it.v12 == 2'b11 && !w_it.v3) |=> r_master)
        else $error("node not master with both channels valid and third leg down");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_tready) |=> ($stable(r_code) && $stable(r_master)))
        else $error("pending result overwritten");
`endif

endmodule

// ===== design/link_master_slave_election.sv =====
`timescale 1ns / 1ps
// Path: a taken tick is written into the queue, then popped into the result register,
// from which its result transfer completes once the receiver is ready.
// Throughput: one tick per clock cycle while the receiver keeps taking results.
// A two-entry queue splits the input side from the result register, so ticks keep
// flowing while one result waits and the queue has room.
// Reset (synchronous, active low): slave, code zero, all channels invalid, queue empty.
// ============================================================================
// link_master_slave_election
// Master/slave election for a two- or three-terminal differential link.
// ============================================================================
module link_master_slave_election #(
    parameter int unsigned QUEUE_DEPTH = lmse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Ticks in. s_tdata from bit 0: local_rx_stable[1:0], peer_rx_stable[1:0],
    // peer_relay_on[1:0], third_leg_seen[1:0], peer1_master, peer1_code[15:0],
    // peer2_master, peer2_code[15:0], fresh_random[15:0], six zero bits.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lmse_pkg::IN_DATA_W-1:0]    s_tdata,
    // Results out. m_tdata from bit 0: is_master, own_code[15:0],
    // valid_mask[2:0], code_renewed, three zero bits.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lmse_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lmse_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lmse_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lmse_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lmse_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;
    t_item    w_item;
    logic     w_full;
    logic     w_pop;
    t_head    w_head;

    // Registers are written in the access phase; the port never inserts waits.
    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three_end   <= 1'b0;
            r_cfg.redundant   <= 1'b0;
            r_cfg.self_loop   <= 2'b00;
            r_cfg.local_relay <= LOCAL_RELAY_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_THREE_END:   r_cfg.three_end   <= pwdata[0];
                REG_REDUNDANT:   r_cfg.redundant   <= pwdata[0];
                REG_SELF_LOOP:   r_cfg.self_loop   <= pwdata[1:0];
                REG_LOCAL_RELAY: r_cfg.local_relay <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            REG_THREE_END:   prdata[0]   = r_cfg.three_end;
            REG_REDUNDANT:   prdata[0]   = r_cfg.redundant;
            REG_SELF_LOOP:   prdata[1:0] = r_cfg.self_loop;
            REG_LOCAL_RELAY: prdata[1:0] = r_cfg.local_relay;
            default: ;
        endcase
    end

    // The front end classifies each tick as it is taken; the queue accepts a
    // transfer whenever it has a free entry.
    lmse_front u_front (
        .i_cfg   (r_cfg),
        .i_tdata (s_tdata),
        .o_item  (w_item)
    );

    assign s_tready = !w_full;

    lmse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_tvalid),
        .i_push_item (w_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    // The election unit takes the queue head whenever its result register is
    // free or being emptied in the same cycle.
    lmse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Testbench for link_master_slave_election
// Drives election ticks through the input stream and checks each result
// against a behavioral model of the election or a hand-written result, over several
// register settings and with random idling on both stream sides.
// ============================================================================
module tb;

    import lmse_pkg::*;

    // Tick fields, declared highest first so that the first field of the
    // stream word lands in the lowest bits.
    typedef struct packed {
        logic [15:0] fresh_random;
        logic [15:0] peer2_code;
        logic        peer2_master;
        logic [15:0] peer1_code;
        logic        peer1_master;
        logic [1:0]  third_leg_seen;
        logic [1:0]  peer_relay_on;
        logic [1:0]  peer_rx_stable;
        logic [1:0]  local_rx_stable;
    } t_tick;

    // Result fields, same packing rule.
    typedef struct packed {
        logic        code_renewed;
        logic [2:0]  valid_mask;
        logic [15:0] own_code;
        logic        is_master;
    } t_verdict;

    // One row of the directed table. When typed is set, want holds the
    // result written out by hand; otherwise the election model decides.
    typedef struct {
        t_cfg     cfg;
        t_tick    tk;
        bit       typed;
        t_verdict want;
    } t_row;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_TICKS  = 175;

    // DUT connections.
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0: local_rx_stable, peer_rx_stable, peer_relay_on,
    // third_leg_seen, peer1_master, peer1_code, peer2_master, peer2_code,
    // fresh_random, zero fill.
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0: is_master, own_code, valid_mask, code_renewed,
    // zero fill.
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    link_master_slave_election u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Election model state. It mirrors the block's registers and the state
    // of the election loop, and it advances once per accepted tick.
    // ------------------------------------------------------------------------
    t_cfg        el_cfg;
    logic        el_master;
    logic [15:0] el_code;
    logic [2:0]  el_valid;
    logic        el_renewed;

    t_verdict pending_verdicts[$];

    // Run bookkeeping.
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned ticks_sent;
    int unsigned renewals_seen;
    int unsigned master_results;
    int unsigned settings_used;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_req;
    int unsigned hold_ack;
    int unsigned hold_left;
    int unsigned holds_done;

    // A tie replaces the local code with the fresh random value.
    function automatic void renew_code(logic [15:0] fresh);
        el_code    = fresh;
        el_renewed = 1'b1;
    endfunction

    // Two-terminal rule against a single peer.
    function automatic void duel_two_end(logic pm, logic [15:0] pc, logic [15:0] fresh);
        if (el_master && pm) begin
            el_master = 1'b0;
        end else if (!el_master && !pm) begin
            if (el_code > pc) begin
                el_master = 1'b1;
            end else if (el_code == pc) begin
                renew_code(fresh);
            end
        end
    endfunction

    // Three-terminal rule when only one channel is valid.
    function automatic void duel_three_end(logic pm, logic [15:0] pc, logic [15:0] fresh);
        if (!el_master && !pm) begin
            if (el_code > pc) begin
                el_master = 1'b1;
            end else if (el_code == pc) begin
                renew_code(fresh);
            end
        end else if (el_master && pm) begin
            if (el_code < pc) begin
                el_master = 1'b0;
            end else if (el_code == pc) begin
                renew_code(fresh);
            end
        end
    endfunction

    // Three-terminal rule with both channels and the third leg valid.
    function automatic void vote_three_way(t_tick tk);
        int unsigned masters;
        bit          largest;
        bit          tie;
        masters = el_master + tk.peer1_master + tk.peer2_master;
        largest = (el_code > tk.peer1_code) && (el_code > tk.peer2_code);
        tie     = (el_code == tk.peer1_code) || (el_code == tk.peer2_code);
        if (masters == 0) begin
            if (largest) begin
                el_master = 1'b1;
            end else if (tie) begin
                renew_code(tk.fresh_random);
            end
        end else if (masters > 1 && el_master && !largest) begin
            el_master = 1'b0;
            if (tie) begin
                renew_code(tk.fresh_random);
            end
        end
    endfunction

    // Advances the model by one tick and returns the result it expects.
    function automatic t_verdict elect_tick(t_tick tk);
        logic [1:0] v12;
        logic       v3;
        t_verdict   r;
        el_renewed = 1'b0;
        v12 = tk.local_rx_stable & tk.peer_rx_stable & ~el_cfg.self_loop;
        if (!el_cfg.three_end) begin
            // The third-leg bit is left alone in two-terminal operation.
            el_valid[1:0] = v12;
            if (v12[0]) begin
                duel_two_end(tk.peer1_master, tk.peer1_code, tk.fresh_random);
            end else if (el_cfg.redundant && v12[1]) begin
                duel_two_end(tk.peer2_master, tk.peer2_code, tk.fresh_random);
            end else begin
                el_master = 1'b0;
            end
        end else begin
            // A channel with protection off at both ends does not count.
            v12 = v12 & (el_cfg.local_relay | tk.peer_relay_on);
            v3  = (v12 != 2'b00) && ((v12 & ~tk.third_leg_seen) == 2'b00);
            el_valid = {v3, v12};
            case (el_valid)
                3'b111: vote_three_way(tk);
                3'b011: el_master = 1'b1;
                3'b001: duel_three_end(tk.peer1_master, tk.peer1_code, tk.fresh_random);
                3'b010: duel_three_end(tk.peer2_master, tk.peer2_code, tk.fresh_random);
                default: el_master = 1'b0;
            endcase
        end
        r.is_master    = el_master;
        r.own_code     = el_code;
        r.valid_mask   = el_valid;
        r.code_renewed = el_renewed;
        return r;
    endfunction

    function automatic t_tick mk_tick(logic [1:0] lrx, logic [1:0] prx, logic [1:0] prl,
                                      logic [1:0] tls, logic m1, logic [15:0] c1,
                                      logic m2, logic [15:0] c2, logic [15:0] fr);
        t_tick tk;
        tk.local_rx_stable = lrx;
        tk.peer_rx_stable  = prx;
        tk.peer_relay_on   = prl;
        tk.third_leg_seen  = tls;
        tk.peer1_master    = m1;
        tk.peer1_code      = c1;
        tk.peer2_master    = m2;
        tk.peer2_code      = c2;
        tk.fresh_random    = fr;
        return tk;
    endfunction

    // Codes for random ticks: often a copy of the local code so that ties
    // happen, often one of a few small values so that the peers tie with
    // each other, otherwise anything.
    function automatic logic [15:0] pick_code();
        case ($urandom_range(3))
            0: return el_code;
            1: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] mostly_set(int unsigned pct);
        if ($urandom_range(99) < pct) begin
            return 2'b11;
        end
        return 2'($urandom);
    endfunction

    function automatic t_tick random_tick();
        t_tick       tk;
        logic [15:0] fr;
        // A small share of ticks are pure noise.
        if ($urandom_range(99) < 5) begin
            tk = t_tick'({$urandom, $urandom});
            return tk;
        end
        case ($urandom_range(9))
            0: fr = 16'h0000;
            1: fr = 16'hFFFF;
            default: fr = 16'($urandom);
        endcase
        tk = mk_tick(mostly_set(75), mostly_set(75), mostly_set(60), mostly_set(60),
                     1'($urandom), pick_code(), 1'($urandom), pick_code(), fr);
        return tk;
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Results are taken at the rising edge where both handshake signals are
    // high, before the block updates anything at that edge.
    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[$bits(t_verdict)-1:0];
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending", got, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.is_master !== want.is_master) begin
                    report_mismatch("is_master", got.is_master, want.is_master);
                end
                if (got.own_code !== want.own_code) begin
                    report_mismatch("own_code", got.own_code, want.own_code);
                end
                if (got.valid_mask !== want.valid_mask) begin
                    report_mismatch("valid_mask", got.valid_mask, want.valid_mask);
                end
                if (got.code_renewed !== want.code_renewed) begin
                    report_mismatch("code_renewed", got.code_renewed, want.code_renewed);
                end
                renewals_seen  += want.code_renewed;
                master_results += want.is_master;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Clock and the run limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // The limit sits far above the slowest correct run: about 1500 ticks,
    // each waiting out both random idling and stalling, plus the long
    // receiver hold-off and the register writes between phases.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, pending_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random, and when the stimulus asks for it, it
    // holds off for a long stretch that it counts itself, so that the output
    // register and the queue fill and the block stops taking ticks.
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one tick, after random idle cycles, and holds it until the
    // transfer completes. The model runs at the accepting edge, so that the
    // next random tick can aim at the updated local code.
    task send_tick(input t_tick tk, input bit typed, input t_verdict want);
        t_verdict v;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(tk);
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        v = elect_tick(tk);
        pending_verdicts.push_back(typed ? want : v);
        ticks_sent++;
    endtask

    // Stops offering and waits until every pending result has come out.
    task settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write: setup cycle, then access cycle. The register takes
    // the value at the edge where the access completes.
    task write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (idx)
            REG_THREE_END:   el_cfg.three_end   = value[0];
            REG_REDUNDANT:   el_cfg.redundant   = value[0];
            REG_SELF_LOOP:   el_cfg.self_loop   = value[1:0];
            REG_LOCAL_RELAY: el_cfg.local_relay = value[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only with the block idle: all results out, then a wait
    // to cover the pipeline.
    task apply_cfg(input t_cfg c);
        settle();
        repeat (3) @(posedge i_clk);
        write_reg(REG_THREE_END,   APB_DATA_W'(c.three_end));
        write_reg(REG_REDUNDANT,   APB_DATA_W'(c.redundant));
        write_reg(REG_SELF_LOOP,   APB_DATA_W'(c.self_loop));
        write_reg(REG_LOCAL_RELAY, APB_DATA_W'(c.local_relay));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Settings used by the rows:
    //   two-terminal single channel at reset values,
    //   two-terminal redundant with channel 1 looped back,
    //   three-terminal with everything looped back and all protection on,
    //   three-terminal with channel 2 looped back,
    //   three-terminal with local protection off on both channels.
    // ------------------------------------------------------------------------
    t_row directed_rows[$];

    task add_row(input t_cfg c, input t_tick tk, input bit typed, input t_verdict want);
        t_row r;
        r.cfg   = c;
        r.tk    = tk;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task build_directed();
        t_cfg     c_two;
        t_cfg     c_red;
        t_cfg     c_loop;
        t_cfg     c_ch2;
        t_cfg     c_three;
        t_verdict none;
        c_two   = t_cfg'{1'b0, 1'b0, 2'b00, LOCAL_RELAY_RST};
        c_red   = t_cfg'{1'b0, 1'b1, 2'b01, 2'b11};
        c_loop  = t_cfg'{1'b1, 1'b1, 2'b11, 2'b11};
        c_ch2   = t_cfg'{1'b1, 1'b0, 2'b10, 2'b11};
        c_three = t_cfg'{1'b1, 1'b0, 2'b00, 2'b00};
        none    = '0;

        // Right after reset with all fields at zero: slave, code zero, nothing valid.
        add_row(c_two, mk_tick(0, 0, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000),
                1'b1, t_verdict'{1'b0, 3'b000, 16'h0000, 1'b0});
        // Code tie with the reset code of zero: the fresh value is loaded.
        add_row(c_two, mk_tick(3, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'hFFFF),
                1'b1, t_verdict'{1'b1, 3'b011, 16'hFFFF, 1'b0});
        // Both slave, own code larger: become master.
        add_row(c_two, mk_tick(3, 3, 0, 0, 0, 16'h0001, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Both master: step down.
        add_row(c_two, mk_tick(3, 3, 0, 0, 1, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Only channel 1 stable at both ends is enough.
        add_row(c_two, mk_tick(1, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Channel 1 down: slave, even with channel 2 fine.
        add_row(c_two, mk_tick(2, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Every field at its maximum.
        add_row(c_two, mk_tick(3, 3, 3, 3, 1, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF), 1'b0, none);

        // Redundant pair, channel 1 looped back: the channel 2 peer decides.
        add_row(c_red, mk_tick(3, 3, 0, 0, 0, 16'h0000, 0, 16'h8000, 16'h1234), 1'b0, none);
        add_row(c_red, mk_tick(3, 3, 0, 0, 0, 16'h0000, 1, 16'h0000, 16'h1234), 1'b0, none);
        add_row(c_red, mk_tick(3, 3, 0, 0, 0, 16'h0000, 0, 16'hFFFF, 16'h1234), 1'b0, none);
        // Neither channel usable: slave.
        add_row(c_red, mk_tick(1, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);

        // Everything looped back: nothing valid.
        add_row(c_loop, mk_tick(3, 3, 3, 3, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Channel 2 looped back, channel 1 alone without the third leg.
        add_row(c_ch2, mk_tick(3, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h5555), 1'b0, none);

        // Local protection off: the peer's flags decide channel validity.
        add_row(c_three, mk_tick(3, 3, 0, 3, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // All three legs valid, nobody master, own code largest.
        add_row(c_three, mk_tick(3, 3, 3, 3, 0, 16'h0000, 0, 16'h0001, 16'h1234), 1'b0, none);
        // Two masters with self among them, own code largest: no change.
        add_row(c_three, mk_tick(3, 3, 3, 3, 1, 16'h0000, 0, 16'h0000, 16'hABCD), 1'b0, none);
        // Self the only master, own code not largest: no change.
        add_row(c_three, mk_tick(3, 3, 3, 3, 0, 16'hABCD, 0, 16'h0000, 16'h0042), 1'b0, none);
        // Two masters with self among them again, own code largest: no change.
        add_row(c_three, mk_tick(3, 3, 3, 3, 1, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Both channels valid but the third leg not: become master.
        add_row(c_three, mk_tick(3, 3, 3, 1, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Only channel 1, both master, own code larger: stay master.
        add_row(c_three, mk_tick(3, 3, 1, 0, 1, 16'h0042, 0, 16'h0000, 16'h7777), 1'b0, none);
        // Only channel 1, both master, own code smaller: step down.
        add_row(c_three, mk_tick(3, 3, 1, 0, 1, 16'hFFFF, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Only channel 2, both slave, own code larger: become master.
        add_row(c_three, mk_tick(3, 3, 2, 0, 0, 16'h0000, 0, 16'h0001, 16'h0000), 1'b0, none);
        // Channel 1 with the third leg but channel 2 down: slave.
        add_row(c_three, mk_tick(3, 3, 1, 1, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
        // Back to two-terminal: the third-leg bit set above must be kept.
        add_row(c_two, mk_tick(3, 3, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000), 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cfg     phase_cfg[RAND_PHASES];
        t_cfg     cur_cfg;
        t_verdict none;

        // Every input known from time zero, with reset held active at the start.
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_ack       = 0;
        hold_left      = 0;
        none           = '0;

        el_cfg    = t_cfg'{1'b0, 1'b0, 2'b00, LOCAL_RELAY_RST};
        el_master = 1'b0;
        el_code   = '0;
        el_valid  = '0;
        cur_cfg   = el_cfg;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling on either side. The first rows run with
        // the registers at their reset values.
        build_directed();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg != cur_cfg) begin
                apply_cfg(directed_rows[i].cfg);
                cur_cfg = directed_rows[i].cfg;
            end
            send_tick(directed_rows[i].tk, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part: one register setting per phase, the extremes first,
        // cycling through the idling patterns.
        phase_cfg[0] = t_cfg'{1'b0, 1'b0, 2'b00, 2'b11};
        phase_cfg[1] = t_cfg'{1'b0, 1'b1, 2'b00, 2'b11};
        phase_cfg[2] = t_cfg'{1'b1, 1'b0, 2'b00, 2'b11};
        phase_cfg[3] = t_cfg'{1'b1, 1'b1, 2'b00, 2'b00};
        phase_cfg[4] = t_cfg'{1'b0, 1'b1, 2'b10, 2'b00};
        phase_cfg[5] = t_cfg'{1'b1, 1'b0, 2'($urandom), 2'($urandom)};
        phase_cfg[6] = t_cfg'(6'($urandom));
        phase_cfg[7] = t_cfg'{1'b1, 1'b0, 2'b01, 2'b10};

        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_cfg(phase_cfg[p]);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            for (int i = 0; i < PHASE_TICKS; i++) begin
                // Long receiver hold-off while ticks keep coming at full rate.
                if (p == 0 && i == 20) begin
                    hold_req++;
                end
                // The sender pauses until every result is out.
                if (p == 1 && i == 80) begin
                    settle();
                end
                send_tick(random_tick(), 1'b0, none);
            end
        end

        settle();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d ticks over %0d register settings and %0d idling patterns,",
                 ticks_sent, settings_used + 1, 4);
        $display("with %0d code renewals, %0d master results and %0d long receiver hold-off(s).",
                 renewals_seen, master_results, holds_done);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
